// ===== rtl/crc32bs_pkg.sv =====
package crc32bs_pkg;

   localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

   // classified item handed from the front to the back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] seed;
      logic        load_seed;
      logic        fold;
      logic        done;
   } crc32bs_op_type;

   // byte-wise reflected CRC step, LSB first
   function automatic logic [31:0] fold_byte(input logic [31:0] crc,
                                             input logic [7:0] data);
      logic [31:0] c;
      c = {24'd0, crc[7:0] ^ data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = CRC_POLY ^ (c >> 1);
         end else begin
            c = c >> 1;
         end
      end
      return c ^ (crc >> 8);
   endfunction

endpackage

// ===== rtl/crc32bs_front.sv =====
module crc32bs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_first_byte,
   input  logic                       req_last_byte,
   input  logic [31:0]                req_seed,
   input  logic                       q_full,
   output logic                       q_push,
   output crc32bs_pkg::crc32bs_op_type q_op
);
   import crc32bs_pkg::*;

   logic stop_on_zero_ff;
   logic stop_on_zero_in;
   logic zero_byte;

   always_comb begin
      stop_on_zero_in = stop_on_zero_ff;
      if (csr_wr_en) begin
         stop_on_zero_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_on_zero_ff <= 1'b0;
      end else begin
         stop_on_zero_ff <= stop_on_zero_in;
      end
   end

   assign zero_byte = (req_data_byte == 8'd0);
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // zero-terminated mode: a zero byte ends the message and is not folded
   always_comb begin
      q_op.data_byte = req_data_byte;
      q_op.seed      = req_seed;
      q_op.load_seed = req_first_byte;
      if (stop_on_zero_ff) begin
         q_op.fold = !zero_byte;
         q_op.done = zero_byte;
      end else begin
         q_op.fold = 1'b1;
         q_op.done = req_last_byte;
      end
   end

endmodule

// ===== rtl/crc32bs_queue.sv =====
module crc32bs_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  crc32bs_pkg::crc32bs_op_type push_op,
   output logic                        full,
   input  logic                        pop,
   output logic                        not_empty,
   output crc32bs_pkg::crc32bs_op_type pop_op
);
   import crc32bs_pkg::*;

   crc32bs_op_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]           count_ff, count_in;
   logic                        do_push, do_pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/crc32bs_back.sv =====
module crc32bs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  crc32bs_pkg::crc32bs_op_type q_op,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [31:0]                 rsp_checksum,
   output logic                        rsp_message_done
);
   import crc32bs_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_checksum_ff, rsp_checksum_in;
   logic        rsp_done_ff, rsp_done_in;
   logic        out_free;
   logic [31:0] base;

   // output register takes a new item when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = q_not_empty && out_free;
   assign base     = q_op.load_seed ? ~q_op.seed : crc_ff;

   always_comb begin
      crc_in          = crc_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_checksum_in = rsp_checksum_ff;
      rsp_done_in     = rsp_done_ff;
      if (out_free) begin
         rsp_valid_in = q_pop;
      end
      if (q_pop) begin
         crc_in          = q_op.fold ? fold_byte(base, q_op.data_byte) : base;
         rsp_checksum_in = ~crc_in;
         rsp_done_in     = q_op.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_checksum_ff <= rsp_checksum_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_checksum     = rsp_checksum_ff;
   assign rsp_message_done = rsp_done_ff;

endmodule

// ===== rtl/crc32_byte_stream.sv =====
// channel | ports                                               | direction
// req     | req_valid, req_stall, data_byte/first/last/seed     | in, one byte per item
// rsp     | rsp_valid, rsp_stall, rsp_checksum, rsp_message_done | out, one result per item
// csr     | csr_wr_en, csr_wr_data (stop_on_zero)                | in, write only
//
// One byte per cycle sustained while rsp_stall is low; a taken item lands in the
// queue at the accepting edge and then moves into the output register, where
// its result is presented. The CRC register closes a loop through the 8-step
// byte fold in the back end.
// Synchronous reset clears the queue and output valid and sets the CRC to ones.
// req_stall rises only when the two-entry queue is full under rsp_stall.
module crc32_byte_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_checksum,
   output logic        rsp_message_done
);
   import crc32bs_pkg::*;

   crc32bs_op_type push_op, pop_op;
   logic           q_push, q_full, q_pop, q_not_empty;

   crc32bs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_seed       (req_seed),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_op           (push_op)
   );

   crc32bs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (push_op),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_op    (pop_op)
   );

   crc32bs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_op             (pop_op),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_checksum     (rsp_checksum),
      .rsp_message_done (rsp_message_done)
   );

endmodule
